@@ sv/imu_fifo_frame_parser_core_assert.svh @@
// ---------------------------------------------------------------------------
// IMU FIFO frame parser assertion macros
// Concurrent assertion shorthands shared by the parser RTL.
// ---------------------------------------------------------------------------
`ifndef IMU_FIFO_FRAME_PARSER_CORE_ASSERT_SVH
`define IMU_FIFO_FRAME_PARSER_CORE_ASSERT_SVH

// same-cycle implication
`define IMUFP_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define IMUFP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/imufp_pkg.sv @@
// ---------------------------------------------------------------------------
// IMU FIFO frame parser package
// Header codes, frame types, result word layout and helpers.
// ---------------------------------------------------------------------------
package imufp_pkg;

	localparam logic [7:0] HDR_ACC      = 8'h84;
	localparam logic [7:0] HDR_GYR      = 8'h88;
	localparam logic [7:0] HDR_BOTH     = 8'h8C;
	localparam logic [7:0] HDR_TIME     = 8'h44;
	localparam logic [7:0] HDR_SKIP     = 8'h40;
	localparam logic [7:0] HDR_CFG      = 8'h48;
	localparam logic [7:0] HDR_OVERREAD = 8'h80;

	localparam int PAYLOAD_DEPTH = 12;
	localparam int PCNT_W        = 4;

	localparam int FL_OVERREAD = 0;
	localparam int FL_TRUNC    = 1;
	localparam int FL_SKIP     = 2;
	localparam int FL_CFG      = 3;
	localparam int FL_TIME     = 4;

	localparam logic [1:0] RK_SAMPLE  = 2'd0;
	localparam logic [1:0] RK_SUCCESS = 2'd1;
	localparam logic [1:0] RK_FAIL    = 2'd2;

	localparam logic [1:0] MASK_ACC  = 2'b01;
	localparam logic [1:0] MASK_GYR  = 2'b10;
	localparam logic [1:0] MASK_BOTH = 2'b11;

	localparam logic [15:0] LIMIT_RESET = 16'hFFFF;
	localparam logic [15:0] TOTAL_MAX   = 16'hFFFF;

	// result queue
	localparam int RES_DEPTH = 4;
	localparam int RPTR_W    = $clog2(RES_DEPTH);
	localparam int RCNT_W    = $clog2(RES_DEPTH + 1);

	typedef enum logic [1:0] {
		PH_HEADER,
		PH_PAYLOAD,
		PH_DONE
	} imufp_phase_t;

	typedef enum logic [2:0] {
		FT_NONE,
		FT_ACC,
		FT_GYR,
		FT_BOTH,
		FT_TIME,
		FT_SKIP,
		FT_CFG
	} imufp_ftype_t;

	typedef struct packed {
		logic [1:0]         kind;
		logic [1:0]         mask;
		logic signed [15:0] gyro_x;
		logic signed [15:0] gyro_y;
		logic signed [15:0] gyro_z;
		logic signed [15:0] accel_x;
		logic signed [15:0] accel_y;
		logic signed [15:0] accel_z;
		logic [4:0]         flags;
		logic [23:0]        stime;
		logic [31:0]        skipped;
		logic [15:0]        total;
	} imufp_result_t;

	function automatic logic [PCNT_W-1:0] frame_need(input imufp_ftype_t t);
		logic [PCNT_W-1:0] n;
		unique case (t)
			FT_ACC:  n = PCNT_W'(6);
			FT_GYR:  n = PCNT_W'(6);
			FT_BOTH: n = PCNT_W'(12);
			FT_TIME: n = PCNT_W'(3);
			FT_SKIP: n = PCNT_W'(1);
			FT_CFG:  n = PCNT_W'(1);
			default: n = '0;
		endcase
		return n;
	endfunction

endpackage

@@ sv/imu_fifo_frame_parser_core.sv @@
// ---------------------------------------------------------------------------
// IMU FIFO frame parser core
// Parses a sensor FIFO dump byte by byte into sample and summary words.
// ---------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-----------------------------------
//  in      | sink      | in_valid/in_stall  | data_byte, end_of_buffer
//  out     | source    | out_valid/out_stall| result_kind .. sample_total
//  cfg     | APB slave | psel/penable/pready| sample_limit at byte address 0
//
//  One byte per cycle while the queue has room: input register, parse logic,
//  then a four-word result queue. A byte gives up to two words (sample,
//  summary). The input register advances while the queue has at least two
//  free slots; parsed words are registered in the queue, which drives out_valid.
//  Reset clears the parse state and the queue; sample_limit resets to 65535.
// ---------------------------------------------------------------------------
module imu_fifo_frame_parser_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         data_byte,
	input  logic               end_of_buffer,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         result_kind,
	output logic [1:0]         content_mask,
	output logic signed [15:0] gyro_x,
	output logic signed [15:0] gyro_y,
	output logic signed [15:0] gyro_z,
	output logic signed [15:0] accel_x,
	output logic signed [15:0] accel_y,
	output logic signed [15:0] accel_z,
	output logic [4:0]         status_flags,
	output logic [23:0]        sensor_ticks,
	output logic [31:0]        skipped_frames,
	output logic [15:0]        sample_total,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);
	import imufp_pkg::*;

	`include "imu_fifo_frame_parser_core_assert.svh"

	logic [15:0] limit_q;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       eob_s1;
	logic       s1_go;
	logic       in_acc;

	imufp_phase_t      phase_q, phase_run, phase_d;
	imufp_ftype_t      ftype_q, hdr_type, ftype_d;
	logic [PCNT_W-1:0] pcnt_q, pcnt_inc, pcnt_d;
	logic [7:0]        pbytes_q [PAYLOAD_DEPTH];
	logic [7:0]        pbytes_n [PAYLOAD_DEPTH];
	logic [4:0]        flags_q, flags_run, flags_d;
	logic [23:0]       time_q, time_d;
	logic [31:0]       skip_q, skip_d;
	logic [15:0]       total_q, total_d;
	logic              hdr_stop;
	logic              frame_done;
	logic              is_data;
	logic              emit_sample;

	imufp_result_t sample_w, summary_w, res_a;
	logic [1:0]    push_n;

	imufp_result_t     resq_q [RES_DEPTH];
	logic [RPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [RCNT_W-1:0] cnt_q;
	logic              pop;

	// config port
	assign pready = 1'b1;
	assign prdata = (paddr[2] == 1'b0) ? {16'd0, limit_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
			limit_q <= pwdata[15:0];
		end
	end

	// input register
	assign s1_go    = valid_s1 && (cnt_q <= RCNT_W'(RES_DEPTH - 2));
	assign in_stall = valid_s1 && !s1_go;
	assign in_acc   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (s1_go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			byte_s1 <= data_byte;
			eob_s1  <= end_of_buffer;
		end
	end

	// header decode
	always_comb begin
		hdr_stop = 1'b0;
		unique case (byte_s1)
			HDR_ACC:  hdr_type = FT_ACC;
			HDR_GYR:  hdr_type = FT_GYR;
			HDR_BOTH: hdr_type = FT_BOTH;
			HDR_TIME: hdr_type = FT_TIME;
			HDR_SKIP: hdr_type = FT_SKIP;
			HDR_CFG:  hdr_type = FT_CFG;
			default: begin
				hdr_type = FT_NONE;
				hdr_stop = 1'b1;
			end
		endcase
	end

	assign pcnt_inc   = pcnt_q + PCNT_W'(1);
	assign frame_done = (phase_q == PH_PAYLOAD) && (pcnt_inc >= frame_need(ftype_q));
	assign is_data    = (ftype_q == FT_ACC) || (ftype_q == FT_GYR) || (ftype_q == FT_BOTH);

	// parse phase, next state
	always_comb begin
		unique case (phase_q)
			PH_HEADER:  phase_run = hdr_stop ? PH_DONE : PH_PAYLOAD;
			PH_PAYLOAD: phase_run = frame_done ? PH_HEADER : PH_PAYLOAD;
			PH_DONE:    phase_run = PH_DONE;
			default:    phase_run = PH_HEADER;
		endcase
		phase_d = eob_s1 ? PH_HEADER : phase_run;
	end

	// parse datapath
	always_comb begin
		pbytes_n = pbytes_q;
		if (phase_q == PH_PAYLOAD && pcnt_q < PCNT_W'(PAYLOAD_DEPTH)) begin
			pbytes_n[pcnt_q] = byte_s1;
		end

		ftype_d     = ftype_q;
		pcnt_d      = pcnt_q;
		flags_run   = flags_q;
		time_d      = time_q;
		skip_d      = skip_q;
		total_d     = total_q;
		emit_sample = 1'b0;

		unique case (phase_q)
			PH_HEADER: begin
				if (hdr_stop) begin
					if (byte_s1 == HDR_OVERREAD) begin
						flags_run[FL_OVERREAD] = 1'b1;
					end else begin
						flags_run[FL_TRUNC] = 1'b1;
					end
				end else begin
					ftype_d = hdr_type;
					pcnt_d  = '0;
				end
			end
			PH_PAYLOAD: begin
				pcnt_d = pcnt_inc;
				if (frame_done) begin
					pcnt_d = '0;
					priority if (is_data) begin
						emit_sample = (total_q < limit_q);
						if (total_q != TOTAL_MAX) begin
							total_d = total_q + 16'd1;
						end
					end else if (ftype_q == FT_TIME) begin
						time_d = {pbytes_n[2], pbytes_n[1], pbytes_n[0]};
						flags_run[FL_TIME] = 1'b1;
					end else if (ftype_q == FT_SKIP) begin
						skip_d = skip_q + {24'd0, pbytes_n[0]};
						flags_run[FL_SKIP] = 1'b1;
					end else begin
						flags_run[FL_CFG] = 1'b1;
					end
				end
			end
			default: begin
			end
		endcase

		flags_d = flags_run;
		if (eob_s1 && phase_run == PH_PAYLOAD) begin
			flags_d[FL_TRUNC] = 1'b1;
		end
	end

	// result words
	always_comb begin
		sample_w = '0;
		sample_w.kind = RK_SAMPLE;
		unique case (ftype_q)
			FT_BOTH: begin
				sample_w.mask    = MASK_BOTH;
				sample_w.gyro_x  = $signed({pbytes_n[1], pbytes_n[0]});
				sample_w.gyro_y  = $signed({pbytes_n[3], pbytes_n[2]});
				sample_w.gyro_z  = $signed({pbytes_n[5], pbytes_n[4]});
				sample_w.accel_x = $signed({pbytes_n[7], pbytes_n[6]});
				sample_w.accel_y = $signed({pbytes_n[9], pbytes_n[8]});
				sample_w.accel_z = $signed({pbytes_n[11], pbytes_n[10]});
			end
			FT_ACC: begin
				sample_w.mask    = MASK_ACC;
				sample_w.accel_x = $signed({pbytes_n[1], pbytes_n[0]});
				sample_w.accel_y = $signed({pbytes_n[3], pbytes_n[2]});
				sample_w.accel_z = $signed({pbytes_n[5], pbytes_n[4]});
			end
			default: begin
				sample_w.mask   = MASK_GYR;
				sample_w.gyro_x = $signed({pbytes_n[1], pbytes_n[0]});
				sample_w.gyro_y = $signed({pbytes_n[3], pbytes_n[2]});
				sample_w.gyro_z = $signed({pbytes_n[5], pbytes_n[4]});
			end
		endcase

		summary_w         = '0;
		summary_w.kind    = flags_d[FL_TRUNC] ? RK_FAIL : RK_SUCCESS;
		summary_w.flags   = flags_d;
		summary_w.stime   = time_d;
		summary_w.skipped = skip_d;
		summary_w.total   = total_d;

		res_a  = emit_sample ? sample_w : summary_w;
		push_n = 2'(emit_sample) + 2'(eob_s1);
	end

	// parse state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			ftype_q <= FT_NONE;
			pcnt_q  <= '0;
			flags_q <= '0;
			time_q  <= '0;
			skip_q  <= '0;
			total_q <= '0;
		end else if (s1_go) begin
			phase_q <= phase_d;
			if (eob_s1) begin
				ftype_q <= FT_NONE;
				pcnt_q  <= '0;
				flags_q <= '0;
				time_q  <= '0;
				skip_q  <= '0;
				total_q <= '0;
			end else begin
				ftype_q <= ftype_d;
				pcnt_q  <= pcnt_d;
				flags_q <= flags_d;
				time_q  <= time_d;
				skip_q  <= skip_d;
				total_q <= total_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go) begin
			pbytes_q <= pbytes_n;
		end
	end

	// result queue
	assign pop = out_valid && !out_stall;

	always_ff @(posedge clk) begin
		if (s1_go && push_n != 2'd0) begin
			resq_q[wr_ptr_q] <= res_a;
		end
		if (s1_go && push_n == 2'd2) begin
			resq_q[wr_ptr_q + RPTR_W'(1)] <= summary_w;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (s1_go) begin
				wr_ptr_q <= wr_ptr_q + RPTR_W'(push_n);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + RPTR_W'(1);
			end
			cnt_q <= cnt_q + RCNT_W'(s1_go ? push_n : 2'd0) - RCNT_W'(pop);
		end
	end

	assign out_valid      = (cnt_q != '0);
	assign result_kind    = resq_q[rd_ptr_q].kind;
	assign content_mask   = resq_q[rd_ptr_q].mask;
	assign gyro_x         = resq_q[rd_ptr_q].gyro_x;
	assign gyro_y         = resq_q[rd_ptr_q].gyro_y;
	assign gyro_z         = resq_q[rd_ptr_q].gyro_z;
	assign accel_x        = resq_q[rd_ptr_q].accel_x;
	assign accel_y        = resq_q[rd_ptr_q].accel_y;
	assign accel_z        = resq_q[rd_ptr_q].accel_z;
	assign status_flags   = resq_q[rd_ptr_q].flags;
	assign sensor_ticks   = resq_q[rd_ptr_q].stime;
	assign skipped_frames = resq_q[rd_ptr_q].skipped;
	assign sample_total   = resq_q[rd_ptr_q].total;

	// checks
	`IMUFP_ASSERT_NOW(a_queue_bound, clk, arst_n, 1'b1, cnt_q <= RCNT_W'(RES_DEPTH), "result queue overflow")
	`IMUFP_ASSERT_NEXT(a_eob_clears, clk, arst_n, s1_go && eob_s1, phase_q == PH_HEADER && flags_q == '0 && total_q == '0, "parse state not cleared after buffer end")
	`IMUFP_ASSERT_NOW(a_go_room, clk, arst_n, s1_go, cnt_q + RCNT_W'(2) <= RCNT_W'(RES_DEPTH), "parse advanced without queue room")

endmodule

@@ verif/tb_imu_fifo_frame_parser_core.sv @@
// ---------------------------------------------------------------------------
// IMU FIFO frame parser core testbench
// Feeds FIFO dumps byte by byte: a directed opening, then random buffers made
// mostly of well-formed frames under several sample limits. Every word is
// checked against an in-bench predictor, field by field, while both sides
// idle at random in part of the run.
// ---------------------------------------------------------------------------
module tb_imu_fifo_frame_parser_core;

	import imufp_pkg::*;

	class imufp_scoreboard;
		logic [15:0]   limit;
		imufp_phase_t  phase;
		imufp_ftype_t  ftype;
		logic [3:0]    pcount;
		logic [7:0]    pbytes [PAYLOAD_DEPTH];
		logic [4:0]    flags;
		logic [23:0]   stime;
		logic [31:0]   skips;
		logic [15:0]   total;
		imufp_result_t words_due [$];
		int            errors;
		int            buffers;
		int            samples_seen;
		int            summaries_seen;

		function new();
			limit = LIMIT_RESET;
			clear_buffer();
		endfunction

		function void clear_buffer();
			phase  = PH_HEADER;
			ftype  = FT_NONE;
			pcount = '0;
			flags  = '0;
			stime  = '0;
			skips  = '0;
			total  = '0;
			foreach (pbytes[i]) pbytes[i] = '0;
		endfunction

		function void open_frame(imufp_ftype_t t);
			ftype  = t;
			pcount = '0;
			phase  = PH_PAYLOAD;
		endfunction

		function logic [15:0] axis_at(int pos);
			return {pbytes[pos + 1], pbytes[pos]};
		endfunction

		// expected words for one accepted byte
		function void note_byte(logic [7:0] b, logic eob);
			imufp_result_t w;
			logic [3:0]    need;
			if (phase == PH_HEADER) begin
				case (b)
					HDR_OVERREAD: begin
						flags[FL_OVERREAD] = 1'b1;
						phase = PH_DONE;
					end
					HDR_ACC:  open_frame(FT_ACC);
					HDR_GYR:  open_frame(FT_GYR);
					HDR_BOTH: open_frame(FT_BOTH);
					HDR_TIME: open_frame(FT_TIME);
					HDR_SKIP: open_frame(FT_SKIP);
					HDR_CFG:  open_frame(FT_CFG);
					default: begin
						flags[FL_TRUNC] = 1'b1;
						phase = PH_DONE;
					end
				endcase
			end else if (phase == PH_PAYLOAD) begin
				if (pcount < 4'd12) pbytes[pcount] = b;
				pcount = pcount + 4'd1;
				case (ftype)
					FT_ACC, FT_GYR: need = 4'd6;
					FT_BOTH:        need = 4'd12;
					FT_TIME:        need = 4'd3;
					default:        need = 4'd1;
				endcase
				if (pcount >= need) begin
					case (ftype)
						FT_ACC, FT_GYR, FT_BOTH: begin
							if (total < limit) begin
								w = '0;
								w.kind = RK_SAMPLE;
								if (ftype == FT_ACC) begin
									w.mask    = MASK_ACC;
									w.accel_x = axis_at(0);
									w.accel_y = axis_at(2);
									w.accel_z = axis_at(4);
								end else begin
									w.mask   = (ftype == FT_BOTH) ? MASK_BOTH : MASK_GYR;
									w.gyro_x = axis_at(0);
									w.gyro_y = axis_at(2);
									w.gyro_z = axis_at(4);
									if (ftype == FT_BOTH) begin
										w.accel_x = axis_at(6);
										w.accel_y = axis_at(8);
										w.accel_z = axis_at(10);
									end
								end
								words_due.push_back(w);
							end
							if (total != TOTAL_MAX) total = total + 16'd1;
						end
						FT_TIME: begin
							stime = {pbytes[2], pbytes[1], pbytes[0]};
							flags[FL_TIME] = 1'b1;
						end
						FT_SKIP: begin
							flags[FL_SKIP] = 1'b1;
							skips = skips + pbytes[0];
						end
						default: flags[FL_CFG] = 1'b1;
					endcase
					phase  = PH_HEADER;
					pcount = '0;
				end
			end
			if (eob) begin
				if (phase == PH_PAYLOAD) flags[FL_TRUNC] = 1'b1;
				w = '0;
				w.kind    = flags[FL_TRUNC] ? RK_FAIL : RK_SUCCESS;
				w.flags   = flags;
				w.stime   = stime;
				w.skipped = skips;
				w.total   = total;
				words_due.push_back(w);
				buffers++;
				clear_buffer();
			end
		endfunction

		function void cmp(string name, logic [63:0] want, logic [63:0] got);
			if (want !== got) begin
				$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
				errors++;
			end
		endfunction

		function void check_word(imufp_result_t got);
			imufp_result_t want;
			if (words_due.size() == 0) begin
				$error("word with nothing expected: kind %0d", got.kind);
				errors++;
				return;
			end
			want = words_due.pop_front();
			if (want.kind == RK_SAMPLE) samples_seen++;
			else summaries_seen++;
			cmp("result_kind", want.kind, got.kind);
			cmp("content_mask", want.mask, got.mask);
			cmp("gyro_x", want.gyro_x, got.gyro_x);
			cmp("gyro_y", want.gyro_y, got.gyro_y);
			cmp("gyro_z", want.gyro_z, got.gyro_z);
			cmp("accel_x", want.accel_x, got.accel_x);
			cmp("accel_y", want.accel_y, got.accel_y);
			cmp("accel_z", want.accel_z, got.accel_z);
			cmp("status_flags", want.flags, got.flags);
			cmp("sensor_ticks", want.stime, got.stime);
			cmp("skipped_frames", want.skipped, got.skipped);
			cmp("sample_total", want.total, got.total);
		endfunction
	endclass

	localparam logic [2:0] ADDR_SAMPLE_LIMIT = 3'd0;
	localparam int RAND_ITEMS  = 1440;
	localparam int CHUNKS      = 6;
	localparam int SETTLE      = 8;
	localparam int HOLD_CYCLES = 150;
	localparam int STUCK_LIMIT = 20000;

	localparam logic [15:0] CHUNK_LIMIT [CHUNKS] =
		'{16'd2, 16'd0, LIMIT_RESET, 16'd1, 16'd4, LIMIT_RESET};

	// bit 8 marks the last byte of a buffer
	localparam logic [8:0] DIRECTED [26] = '{
		{1'b0, HDR_BOTH}, 9'h000, 9'h080, 9'h0FF, 9'h07F, 9'h001, 9'h000,
		9'h0FF, 9'h0FF, 9'h034, 9'h012, 9'h0AA, 9'h155,
		{1'b0, HDR_TIME}, 9'h056, 9'h034, 9'h012,
		{1'b0, HDR_SKIP}, 9'h0FF, {1'b0, HDR_CFG}, 9'h000,
		{1'b0, HDR_OVERREAD}, 9'h111,
		{1'b0, HDR_GYR}, 9'h101,
		9'h1FF
	};

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic [7:0]         data_byte;
	logic               end_of_buffer;
	logic               out_valid;
	logic               out_stall;
	logic [1:0]         result_kind;
	logic [1:0]         content_mask;
	logic signed [15:0] gyro_x;
	logic signed [15:0] gyro_y;
	logic signed [15:0] gyro_z;
	logic signed [15:0] accel_x;
	logic signed [15:0] accel_y;
	logic signed [15:0] accel_z;
	logic [4:0]         status_flags;
	logic [23:0]        sensor_ticks;
	logic [31:0]        skipped_frames;
	logic [15:0]        sample_total;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [2:0]         paddr;
	logic [31:0]        pwdata;
	logic [31:0]        prdata;
	logic               pready;

	imufp_scoreboard sb;
	logic [8:0]      stream [$];
	int              tx_pct;
	int              rx_pct;
	int              bytes_sent;
	bit              hold_req;
	bit              hold_done;
	int              hold_left;

	imu_fifo_frame_parser_core dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.data_byte      (data_byte),
		.end_of_buffer  (end_of_buffer),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.result_kind    (result_kind),
		.content_mask   (content_mask),
		.gyro_x         (gyro_x),
		.gyro_y         (gyro_y),
		.gyro_z         (gyro_z),
		.accel_x        (accel_x),
		.accel_y        (accel_y),
		.accel_z        (accel_z),
		.status_flags   (status_flags),
		.sensor_ticks   (sensor_ticks),
		.skipped_frames (skipped_frames),
		.sample_total   (sample_total),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [7:0] rand_byte();
		case ($urandom_range(0, 7))
			0:       return 8'h00;
			1:       return 8'hFF;
			2:       return 8'h80;
			3:       return 8'h7F;
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic void add_frame();
		int         pick;
		int         len;
		logic [7:0] hdr;
		pick = $urandom_range(0, 99);
		if (pick < 25) begin
			hdr = HDR_ACC;  len = 6;
		end else if (pick < 50) begin
			hdr = HDR_GYR;  len = 6;
		end else if (pick < 72) begin
			hdr = HDR_BOTH; len = 12;
		end else if (pick < 82) begin
			hdr = HDR_TIME; len = 3;
		end else if (pick < 92) begin
			hdr = HDR_SKIP; len = 1;
		end else begin
			hdr = HDR_CFG;  len = 1;
		end
		stream.push_back({1'b0, hdr});
		repeat (len) stream.push_back({1'b0, rand_byte()});
	endfunction

	// mostly well-formed buffers; some are random bytes, some end in overread, a bad header or a cut
	function automatic void make_buffer();
		int         pick;
		int         keep;
		logic [7:0] hb;
		stream.delete();
		pick = $urandom_range(0, 99);
		if (pick < 5) begin
			repeat ($urandom_range(1, 10)) stream.push_back({1'b0, 8'($urandom)});
		end else begin
			repeat ($urandom_range(1, 6)) add_frame();
			pick = $urandom_range(0, 99);
			if (pick < 8) begin
				stream.push_back({1'b0, HDR_OVERREAD});
				repeat ($urandom_range(0, 4)) stream.push_back({1'b0, rand_byte()});
			end else if (pick < 15) begin
				do hb = 8'($urandom);
				while (hb inside {HDR_ACC, HDR_GYR, HDR_BOTH, HDR_TIME, HDR_SKIP,
					HDR_CFG, HDR_OVERREAD});
				stream.push_back({1'b0, hb});
				repeat ($urandom_range(0, 3)) stream.push_back({1'b0, rand_byte()});
			end else if (pick < 25) begin
				keep = $urandom_range(1, stream.size() - 1);
				while (stream.size() > keep) void'(stream.pop_back());
			end
		end
		stream[stream.size() - 1][8] = 1'b1;
	endfunction

	// called at a falling edge, returns at a falling edge
	task automatic send_byte(input logic [7:0] b, input logic eob);
		while ($urandom_range(0, 99) < tx_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid      = 1'b1;
		data_byte     = b;
		end_of_buffer = eob;
		do @(posedge clk); while (in_stall);
		sb.note_byte(b, eob);
		bytes_sent++;
		@(negedge clk);
	endtask

	task automatic send_stream();
		foreach (stream[i]) send_byte(stream[i][7:0], stream[i][8]);
	endtask

	task automatic settle();
		in_valid = 1'b0;
		while (sb.words_due.size() != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	// write then read back
	task automatic cfg_write(input logic [15:0] value);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = ADDR_SAMPLE_LIMIT;
		pwdata  = {16'h0000, value};
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		sb.limit = value;
		@(negedge clk);
		penable = 1'b0;
		pwrite  = 1'b0;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata[15:0] !== value) begin
			$error("sample_limit readback: expected 0x%0h, got 0x%0h", value, prdata[15:0]);
			sb.errors++;
		end
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
	endtask

	always @(negedge clk) begin
		if (hold_req && !hold_done) begin
			hold_done = 1'b1;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			out_stall = 1'b1;
			hold_left--;
		end else begin
			out_stall = ($urandom_range(0, 99) < rx_pct);
		end
	end

	always @(posedge clk) begin : word_monitor
		imufp_result_t got;
		if (arst_n && out_valid && !out_stall) begin
			got.kind    = result_kind;
			got.mask    = content_mask;
			got.gyro_x  = gyro_x;
			got.gyro_y  = gyro_y;
			got.gyro_z  = gyro_z;
			got.accel_x = accel_x;
			got.accel_y = accel_y;
			got.accel_z = accel_z;
			got.flags   = status_flags;
			got.stime   = sensor_ticks;
			got.skipped = skipped_frames;
			got.total   = sample_total;
			sb.check_word(got);
		end
	end

	initial begin : watchdog
		int stuck;
		stuck = 0;
		while (stuck < STUCK_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel) stuck = 0;
			else stuck++;
		end
		$display("timeout: nothing moved for %0d cycles", STUCK_LIMIT);
		$display("** imu_fifo_frame_parser_core: FAILED **");
		$finish;
	end

	initial begin : main_seq
		int chunk_bytes;
		sb            = new();
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		data_byte     = '0;
		end_of_buffer = 1'b0;
		out_stall     = 1'b0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = ADDR_SAMPLE_LIMIT;
		pwdata        = '0;
		tx_pct        = 0;
		rx_pct        = 0;
		bytes_sent    = 0;
		hold_req      = 1'b0;
		hold_done     = 1'b0;
		hold_left     = 0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		cfg_write(LIMIT_RESET);
		foreach (DIRECTED[i]) send_byte(DIRECTED[i][7:0], DIRECTED[i][8]);
		settle();

		for (int c = 0; c < CHUNKS; c++) begin
			cfg_write(CHUNK_LIMIT[c]);
			tx_pct = (c < 2) ? 35 : (c < 4) ? 53 : 0;
			rx_pct = (c < 2) ? 53 : (c < 4) ? 35 : 0;
			if (c == 0) hold_req = 1'b1;
			chunk_bytes = 0;
			while (chunk_bytes < RAND_ITEMS / CHUNKS) begin
				make_buffer();
				send_stream();
				chunk_bytes += stream.size();
			end
			settle();
		end

		$display("%0d bytes in %0d buffers; %0d sample and %0d summary words checked",
			bytes_sent, sb.buffers, sb.samples_seen, sb.summaries_seen);
		$display("sample limits 0 to 65535, idle and hold-off on both sides, bad and cut buffers");
		if (sb.errors == 0 && sb.words_due.size() == 0) begin
			$display("** imu_fifo_frame_parser_core: PASSED **");
		end else begin
			$display("** imu_fifo_frame_parser_core: FAILED **");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
+incdir+sv
sv/imufp_pkg.sv
sv/imu_fifo_frame_parser_core.sv
verif/tb_imu_fifo_frame_parser_core.sv
